/* design/hxcpu_pkg.sv */
// types and constants for the teaching cpu step block
// no dependencies; compiled first
package hxcpu_pkg;

	localparam int unsigned ADDR_W = 8;
	localparam int unsigned WORD_W = 16;
	localparam int unsigned RIDX_W = 4;
	localparam int unsigned PC_W   = 8;

	// transaction kinds on the item channel
	typedef enum logic [1:0] {
		ITEM_WRITE_MEM = 2'd0,
		ITEM_EXECUTE   = 2'd1,
		ITEM_READ_REG  = 2'd2,
		ITEM_READ_MEM  = 2'd3
	} item_op_t;

	// instruction opcodes (top nibble)
	localparam logic [3:0] INS_LOAD  = 4'h1;
	localparam logic [3:0] INS_IMM   = 4'h2;
	localparam logic [3:0] INS_STORE = 4'h3;
	localparam logic [3:0] INS_ADD   = 4'h5;
	localparam logic [3:0] INS_PRINT = 4'h6;
	localparam logic [3:0] INS_JZ    = 4'hB;

	localparam logic [WORD_W-1:0] HALT_WORD = 16'hC000;

	typedef struct packed {
		item_op_t            opcode;
		logic [ADDR_W-1:0]   mem_address;
		logic [WORD_W-1:0]   write_word;
		logic [RIDX_W-1:0]   reg_index;
	} item_t;

	typedef struct packed {
		logic                halted;
		logic [PC_W-1:0]     pc_value;
		logic [WORD_W-1:0]   instr_word;
		logic                print_valid;
		logic [WORD_W-1:0]   print_value;
		logic [WORD_W-1:0]   read_data;
	} result_t;

	typedef enum logic [1:0] {
		ST_ISSUE,
		ST_READ,
		ST_DECODE,
		ST_EXEC
	} state_t;

endpackage

/* design/hxcpu_item_if.sv */
// valid/ready channel carrying one input item
// depends on hxcpu_pkg
interface hxcpu_item_if;
	logic              valid;
	logic              ready;
	hxcpu_pkg::item_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* design/hxcpu_result_if.sv */
// valid/ready channel carrying one result item
// depends on hxcpu_pkg
interface hxcpu_result_if;
	logic                valid;
	logic                ready;
	hxcpu_pkg::result_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* design/hex_teaching_cpu_step_top.sv */
// teaching cpu step: sequencer around a main memory and a register file
// depends on hxcpu_pkg, hxcpu_item_if, hxcpu_result_if
//
// One result transaction per item transaction, in order. The item is taken
// into a one-entry buffer, so the next item is accepted in the cycle the
// current one finishes; a result waits in an output register, and no item
// finishes while it is untaken. Steps follow the registered reads of the
// synchronous memory and register file: a memory write finishes in issue, a
// register or memory read sends the address in issue and takes the data in
// read, an instruction fetches at the counter in issue, reads operands in
// decode, then executes and writes back in exec; a halt word ends in decode.
// Both stores come out of reset reading zero through per-entry valid bits,
// so there is no clearing pass and items are accepted right after reset. All
// writes commit in the cycle the result is loaded, the next item reads no
// earlier than the cycle after; accesses never overlap, so no forwarding.
module hex_teaching_cpu_step_top #(
	parameter int unsigned REG_COUNT = 16,
	parameter int unsigned MEM_DEPTH = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	hxcpu_item_if.sink            item,
	hxcpu_result_if.source        result
);

	localparam int unsigned MEM_AW = $clog2(MEM_DEPTH);
	localparam int unsigned RF_AW  = $clog2(REG_COUNT);

	// input buffer and control
	logic                          item_vld_q;
	hxcpu_pkg::item_t              item_q;
	hxcpu_pkg::state_t             state_q, state_d;
	logic [hxcpu_pkg::PC_W-1:0]    pc_q, pc_d;
	logic [hxcpu_pkg::WORD_W-1:0]  ir_q, ir_d;
	logic                          pc_ld, ir_ld;
	logic                          done;
	logic                          out_free;
	logic                          out_vld_q;
	hxcpu_pkg::result_t            out_q, res;

	// main memory, valid bit per word so reset reads as zero
	logic [hxcpu_pkg::WORD_W-1:0]  mem_q [MEM_DEPTH];
	logic [MEM_DEPTH-1:0]          mem_vld_q;
	logic [hxcpu_pkg::WORD_W-1:0]  mem_rd_q;
	logic                          mem_rd_vld_q;
	logic                          mem_re, mem_we;
	logic [MEM_AW-1:0]             mem_ra, mem_wa;
	logic [hxcpu_pkg::WORD_W-1:0]  mem_wd;
	logic [hxcpu_pkg::WORD_W-1:0]  mem_word;

	// register file, two read ports and one write port
	logic [hxcpu_pkg::WORD_W-1:0]  rf_q [REG_COUNT];
	logic [REG_COUNT-1:0]          rf_vld_q;
	logic [hxcpu_pkg::WORD_W-1:0]  rfa_q, rfb_q;
	logic                          rfa_vld_q, rfb_vld_q;
	logic                          rf_rea, rf_reb, rf_we;
	logic [RF_AW-1:0]              rf_raa, rf_rab, rf_wa;
	logic [hxcpu_pkg::WORD_W-1:0]  rf_wd;
	logic [hxcpu_pkg::WORD_W-1:0]  rfa_word, rfb_word;

	// candidate writes of the execute step, committed with the result
	logic                          ex_mem_we, ex_rf_we;
	logic [3:0]                    ins_op;
	logic [hxcpu_pkg::PC_W-1:0]    pc_next;

	assign mem_word = mem_rd_vld_q ? mem_rd_q : '0;
	assign rfa_word = rfa_vld_q ? rfa_q : '0;
	assign rfb_word = rfb_vld_q ? rfb_q : '0;
	assign ins_op   = ir_q[15:12];

	assign out_free    = !out_vld_q || result.ready;
	assign item.ready  = !item_vld_q || done;
	assign result.valid = out_vld_q;
	assign result.data  = out_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hxcpu_pkg::ST_ISSUE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state, memory ports and result
	always_comb begin
		state_d   = state_q;
		done      = 1'b0;
		mem_re    = 1'b0;
		mem_ra    = '0;
		mem_we    = 1'b0;
		mem_wa    = '0;
		mem_wd    = '0;
		rf_rea    = 1'b0;
		rf_raa    = '0;
		rf_reb    = 1'b0;
		rf_rab    = '0;
		rf_we     = 1'b0;
		rf_wa     = '0;
		rf_wd     = '0;
		ex_mem_we = 1'b0;
		ex_rf_we  = 1'b0;
		pc_ld     = 1'b0;
		ir_ld     = 1'b0;
		ir_d      = mem_word;
		pc_next   = pc_q + 1'b1;
		pc_d      = pc_next;
		res       = '0;
		res.pc_value   = pc_q;
		res.instr_word = ir_q;

		unique case (state_q)
			hxcpu_pkg::ST_ISSUE: begin
				if (item_vld_q) begin
					unique case (item_q.opcode)
						hxcpu_pkg::ITEM_WRITE_MEM: begin
							if (out_free) begin
								mem_we = 1'b1;
								mem_wa = item_q.mem_address[MEM_AW-1:0];
								mem_wd = item_q.write_word;
								done   = 1'b1;
							end
						end
						hxcpu_pkg::ITEM_EXECUTE: begin
							// fetch at the counter
							mem_re  = 1'b1;
							mem_ra  = pc_q[MEM_AW-1:0];
							state_d = hxcpu_pkg::ST_DECODE;
						end
						hxcpu_pkg::ITEM_READ_REG: begin
							rf_rea  = 1'b1;
							rf_raa  = item_q.reg_index[RF_AW-1:0];
							state_d = hxcpu_pkg::ST_READ;
						end
						hxcpu_pkg::ITEM_READ_MEM: begin
							mem_re  = 1'b1;
							mem_ra  = item_q.mem_address[MEM_AW-1:0];
							state_d = hxcpu_pkg::ST_READ;
						end
						default: ;
					endcase
				end
			end
			hxcpu_pkg::ST_READ: begin
				res.read_data = (item_q.opcode == hxcpu_pkg::ITEM_READ_REG) ?
					rfa_word : mem_word;
				if (out_free) begin
					done    = 1'b1;
					state_d = hxcpu_pkg::ST_ISSUE;
				end
			end
			hxcpu_pkg::ST_DECODE: begin
				ir_ld = 1'b1;
				if (mem_word == hxcpu_pkg::HALT_WORD) begin
					// halt: counter held, wait here for the output slot
					res.halted     = 1'b1;
					res.instr_word = mem_word;
					if (out_free) begin
						done    = 1'b1;
						state_d = hxcpu_pkg::ST_ISSUE;
					end
				end else begin
					// operand reads: mem[xy], reg[r], reg[s]
					mem_re  = 1'b1;
					mem_ra  = mem_word[MEM_AW-1:0];
					rf_rea  = 1'b1;
					rf_raa  = mem_word[8 +: RF_AW];
					rf_reb  = 1'b1;
					rf_rab  = mem_word[4 +: RF_AW];
					state_d = hxcpu_pkg::ST_EXEC;
				end
			end
			hxcpu_pkg::ST_EXEC: begin
				unique case (ins_op)
					hxcpu_pkg::INS_LOAD: begin
						ex_rf_we = 1'b1;
						rf_wa    = ir_q[8 +: RF_AW];
						rf_wd    = mem_word;
					end
					hxcpu_pkg::INS_IMM: begin
						ex_rf_we = 1'b1;
						rf_wa    = ir_q[8 +: RF_AW];
						rf_wd    = {8'h00, ir_q[7:0]};
					end
					hxcpu_pkg::INS_STORE: begin
						ex_mem_we = 1'b1;
						mem_wa    = ir_q[MEM_AW-1:0];
						mem_wd    = rfa_word;
					end
					hxcpu_pkg::INS_JZ: begin
						if (rfa_word == '0) begin
							pc_next = ir_q[7:0];
						end
					end
					hxcpu_pkg::INS_ADD: begin
						ex_rf_we = 1'b1;
						rf_wa    = ir_q[RF_AW-1:0];
						rf_wd    = rfa_word + rfb_word;
					end
					hxcpu_pkg::INS_PRINT: begin
						res.print_valid = 1'b1;
						res.print_value = rfa_word;
					end
					default: ;
				endcase
				pc_d         = pc_next;
				res.pc_value = pc_next;
				if (out_free) begin
					mem_we  = ex_mem_we;
					rf_we   = ex_rf_we;
					pc_ld   = 1'b1;
					done    = 1'b1;
					state_d = hxcpu_pkg::ST_ISSUE;
				end
			end
			default: state_d = hxcpu_pkg::ST_ISSUE;
		endcase
	end

	// item buffer, counter, instruction register, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
			pc_q       <= '0;
			ir_q       <= '0;
		end else begin
			if (item.valid && item.ready) begin
				item_vld_q <= 1'b1;
			end else if (done) begin
				item_vld_q <= 1'b0;
			end
			if (done) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
			if (pc_ld) begin
				pc_q <= pc_d;
			end
			if (ir_ld) begin
				ir_q <= ir_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_q <= item.data;
		end
		if (done) begin
			out_q <= res;
		end
	end

	// valid bits and read-data valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_vld_q    <= '0;
			mem_rd_vld_q <= 1'b0;
			rf_vld_q     <= '0;
			rfa_vld_q    <= 1'b0;
			rfb_vld_q    <= 1'b0;
		end else begin
			if (mem_re) begin
				mem_rd_vld_q <= mem_vld_q[mem_ra];
			end
			if (mem_we) begin
				mem_vld_q[mem_wa] <= 1'b1;
			end
			if (rf_rea) begin
				rfa_vld_q <= rf_vld_q[rf_raa];
			end
			if (rf_reb) begin
				rfb_vld_q <= rf_vld_q[rf_rab];
			end
			if (rf_we) begin
				rf_vld_q[rf_wa] <= 1'b1;
			end
		end
	end

	// main memory: one read port, one write port
	always_ff @(posedge clk) begin
		if (mem_re) begin
			mem_rd_q <= mem_q[mem_ra];
		end
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
	end

	// register file: two read ports, one write port
	always_ff @(posedge clk) begin
		if (rf_rea) begin
			rfa_q <= rf_q[rf_raa];
		end
		if (rf_reb) begin
			rfb_q <= rf_q[rf_rab];
		end
		if (rf_we) begin
			rf_q[rf_wa] <= rf_wd;
		end
	end

	// engine only leaves issue with an item in the buffer
	a_busy_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != hxcpu_pkg::ST_ISSUE |-> item_vld_q)
		else $error("engine busy without a buffered item");

	// counter moves only when a result transaction is loaded
	a_pc_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		!done |=> $stable(pc_q))
		else $error("program counter changed without a result");

	// state writes commit together with the result
	a_write_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we || rf_we) |-> done)
		else $error("store written without a result");

endmodule
